// ===== design/pidpc_pkg.sv =====
// Shared types and fixed constants of the PID position controller.
package pidpc_pkg;

   // Step time format: unsigned Q8.24 seconds
   localparam int DT_WIDTH = 32;
   localparam int DT_FRAC  = 24;

   // Register file layout
   localparam int NUM_REGS        = 7;
   localparam int REG_INDEX_WIDTH = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_INTEG_FLOOR   = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_INTEG_CEILING = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_DRIVE_FLOOR   = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_DRIVE_CEILING = 3'd6;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_PREP,
      ST_SERIAL,
      ST_INTEG,
      ST_MAC_LOAD,
      ST_MAC_RUN,
      ST_EFFORT,
      ST_DONE
   } state_type;

endpackage

// ===== design/pid_position_controller.sv =====
// PID position controller: one joint, bit-serial multiply and divide datapath.
//
// A request carries setpoint, measured position (signed fixed point,
// FRAC_BITS fraction bits) and the step time (unsigned Q8.24 seconds).
// Each request gives exactly one response, the saturated drive effort.
// Gains and clamp limits sit in an APB-style register bank at byte address
// 4*i (8*i when DATA_WIDTH exceeds 32); write it only while idle.
// One request is worked on at a time: the result is loaded into the output
// register, the block returns to idle and only then takes a new request.
// The working time is set by the restoring divider for the derivative
// (DATA_WIDTH+25 quotient bits, one per cycle, with the integral product
// running beside it) and by the shared one-bit-per-cycle multiplier that
// then forms the three gain products in turn.
// Reset clears the integral and the last error and loads the default
// gains (zero) and limits (+-100.0, saturated to the data width).
// The result waits in an output register; while the receiver stalls the
// block still takes and works on the next request, and holds in its final
// state only if the earlier response has not yet been taken.
module pid_position_controller import pidpc_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16,
   localparam int CSR_WIDTH = (DATA_WIDTH > 32) ? 64 : 32,
   localparam int CSR_ADDR_WIDTH = REG_INDEX_WIDTH + ((DATA_WIDTH > 32) ? 3 : 2)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_setpoint,
   input  logic signed [DATA_WIDTH-1:0] req_measured,
   input  logic        [DT_WIDTH-1:0]   req_step_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_effort,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [CSR_WIDTH-1:0]         csr_pwdata,
   output logic [CSR_WIDTH-1:0]         csr_prdata,
   output logic                         csr_pready
);

   localparam int DW            = DATA_WIDTH;
   localparam int STRIDE_BITS   = CSR_ADDR_WIDTH - REG_INDEX_WIDTH;
   localparam int PROD_WIDTH    = DW + DT_WIDTH + 1;
   localparam int GSUM_WIDTH    = 2 * DW + 2;
   localparam int MUL_WIDTH     = (PROD_WIDTH > GSUM_WIDTH) ? PROD_WIDTH : GSUM_WIDTH;
   localparam int MPLIER_WIDTH  = (DW > DT_WIDTH) ? DW : DT_WIDTH;
   localparam int MUL_CNT_WIDTH = $clog2(MPLIER_WIDTH + 1);
   localparam int NUM_WIDTH     = DW + 1 + DT_FRAC;
   localparam int DIV_CNT_WIDTH = $clog2(NUM_WIDTH + 1);
   localparam int STEP_WIDTH    = PROD_WIDTH - DT_FRAC;
   localparam int ISUM_WIDTH    = STEP_WIDTH + 1;

   localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

   // Reset limits of +-100.0, saturated to the data width
   localparam longint HUNDRED    = 64'sd100 <<< FRAC_BITS;
   localparam longint SMAX_LONG  = (64'sd1 <<< (DW - 1)) - 64'sd1;
   localparam logic signed [DW-1:0] RST_CEILING =
      DW'((HUNDRED > SMAX_LONG) ? SMAX_LONG : HUNDRED);
   localparam logic signed [DW-1:0] RST_FLOOR =
      DW'((HUNDRED > SMAX_LONG) ? (-SMAX_LONG - 64'sd1) : -HUNDRED);

   // Gain products, taken in this order
   localparam logic [1:0] TERM_PROP  = 2'd0;
   localparam logic [1:0] TERM_INTEG = 2'd1;
   localparam logic [1:0] TERM_DERIV = 2'd2;

   state_type state_ff, state_in;

   // Register bank
   logic signed [DW-1:0] prop_gain_ff, prop_gain_in;
   logic signed [DW-1:0] integ_gain_ff, integ_gain_in;
   logic signed [DW-1:0] deriv_gain_ff, deriv_gain_in;
   logic signed [DW-1:0] integ_floor_ff, integ_floor_in;
   logic signed [DW-1:0] integ_ceiling_ff, integ_ceiling_in;
   logic signed [DW-1:0] drive_floor_ff, drive_floor_in;
   logic signed [DW-1:0] drive_ceiling_ff, drive_ceiling_in;

   // Request payload
   logic signed [DW-1:0]       setpoint_ff, measured_ff;
   logic        [DT_WIDTH-1:0] step_time_ff;

   // Controller state and intermediate values
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [DW-1:0] last_err_ff, last_err_in;
   logic signed [DW-1:0] integ_ff, integ_in;
   logic signed [DW-1:0] deriv_ff, deriv_in;
   logic signed [DW-1:0] eff_ff, eff_in;
   logic                 diff_neg_ff, diff_neg_in;
   logic [1:0]           term_ff, term_in;

   // Shift-add multiplier
   logic signed [MUL_WIDTH-1:0] mul_acc_ff, mul_acc_in;
   logic [MUL_WIDTH-1:0]        mul_mcand_ff, mul_mcand_in;
   logic [MPLIER_WIDTH-1:0]     mul_mplier_ff, mul_mplier_in;
   logic [MUL_CNT_WIDTH-1:0]    mul_left_ff, mul_left_in;
   logic                        mul_signed_ff, mul_signed_in;

   // Restoring divider
   logic [NUM_WIDTH-1:0]     div_num_ff, div_num_in;
   logic [DT_WIDTH-1:0]      div_rem_ff, div_rem_in;
   logic [DIV_CNT_WIDTH-1:0] div_left_ff, div_left_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_effort_ff, rsp_effort_in;

   logic req_take;
   logic rsp_load;
   logic csr_write;
   logic [REG_INDEX_WIDTH-1:0] csr_index;
   logic signed [DW-1:0] csr_value;

   logic signed [DW:0]          err_raw;
   logic signed [DW-1:0]        err_sat;
   logic signed [DW:0]          err_diff;
   logic [DW:0]                 err_mag;
   logic signed [MUL_WIDTH-1:0] mul_sum;
   logic                        mul_busy;
   logic [DT_WIDTH:0]           div_trial;
   logic                        div_fits;
   logic [DT_WIDTH-1:0]         div_rem_next;
   logic                        div_busy;
   logic signed [PROD_WIDTH-1:0] int_prod;
   logic signed [STEP_WIDTH-1:0] int_step;
   logic signed [ISUM_WIDTH-1:0] int_sum;
   logic [ISUM_WIDTH-DW:0]       int_top;
   logic signed [DW-1:0]         int_sat;
   logic                         quot_big;
   logic [DW-1:0]                quot_low;
   logic signed [DW-1:0]         deriv_val;
   logic signed [MUL_WIDTH-1:0]  eff_shift;
   logic [MUL_WIDTH-DW:0]        eff_top;
   logic signed [DW-1:0]         eff_sat;

   // Raise to the floor first, then lower to the ceiling
   function automatic logic signed [DW-1:0] clamp_value(
      input logic signed [DW-1:0] value,
      input logic signed [DW-1:0] floor_v,
      input logic signed [DW-1:0] ceil_v
   );
      logic signed [DW-1:0] res;
      res = (value < floor_v) ? floor_v : value;
      res = (res > ceil_v) ? ceil_v : res;
      return res;
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:STRIDE_BITS];
   assign csr_value  = csr_pwdata[DW-1:0];

   always_comb begin
      prop_gain_in     = prop_gain_ff;
      integ_gain_in    = integ_gain_ff;
      deriv_gain_in    = deriv_gain_ff;
      integ_floor_in   = integ_floor_ff;
      integ_ceiling_in = integ_ceiling_ff;
      drive_floor_in   = drive_floor_ff;
      drive_ceiling_in = drive_ceiling_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:     prop_gain_in     = csr_value;
            REG_INTEG_GAIN:    integ_gain_in    = csr_value;
            REG_DERIV_GAIN:    deriv_gain_in    = csr_value;
            REG_INTEG_FLOOR:   integ_floor_in   = csr_value;
            REG_INTEG_CEILING: integ_ceiling_in = csr_value;
            REG_DRIVE_FLOOR:   drive_floor_in   = csr_value;
            REG_DRIVE_CEILING: drive_ceiling_in = csr_value;
            default:           prop_gain_in     = prop_gain_ff;
         endcase
      end
   end

   // Read back, sign extended to the bus
   always_comb begin
      case (csr_index)
         REG_PROP_GAIN:     csr_prdata = CSR_WIDTH'(prop_gain_ff);
         REG_INTEG_GAIN:    csr_prdata = CSR_WIDTH'(integ_gain_ff);
         REG_DERIV_GAIN:    csr_prdata = CSR_WIDTH'(deriv_gain_ff);
         REG_INTEG_FLOOR:   csr_prdata = CSR_WIDTH'(integ_floor_ff);
         REG_INTEG_CEILING: csr_prdata = CSR_WIDTH'(integ_ceiling_ff);
         REG_DRIVE_FLOOR:   csr_prdata = CSR_WIDTH'(drive_floor_ff);
         REG_DRIVE_CEILING: csr_prdata = CSR_WIDTH'(drive_ceiling_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_ERROR;
         ST_ERROR:    state_in = ST_PREP;
         ST_PREP:     state_in = ST_SERIAL;
         ST_SERIAL:   if (!mul_busy && !div_busy) state_in = ST_INTEG;
         ST_INTEG:    state_in = ST_MAC_LOAD;
         ST_MAC_LOAD: state_in = ST_MAC_RUN;
         ST_MAC_RUN: begin
            if (!mul_busy) state_in = (term_ff == TERM_DERIV) ? ST_EFFORT : ST_MAC_LOAD;
         end
         ST_EFFORT:   state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DONE: rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            rsp_load  = 1'b0;
         end
      endcase
   end

   assign req_take = req_valid && req_ready;

   // Saturated error and its change since the last request
   assign err_raw  = (DW+1)'(setpoint_ff) - (DW+1)'(measured_ff);
   assign err_sat  = (err_raw[DW] != err_raw[DW-1]) ? (err_raw[DW] ? SMIN : SMAX)
                                                     : err_raw[DW-1:0];
   assign err_diff = (DW+1)'(err_ff) - (DW+1)'(last_err_ff);
   assign err_mag  = err_diff[DW] ? (DW+1)'(-err_diff) : err_diff;

   // One multiplier bit per cycle; the multiplier's sign bit subtracts
   assign mul_busy = (mul_left_ff != '0);
   assign mul_sum  = !mul_mplier_ff[0] ? mul_acc_ff :
                     (mul_signed_ff && mul_left_ff == MUL_CNT_WIDTH'(1))
                        ? mul_acc_ff - $signed(mul_mcand_ff)
                        : mul_acc_ff + $signed(mul_mcand_ff);

   // One quotient bit per cycle
   assign div_busy     = (div_left_ff != '0);
   assign div_trial    = {div_rem_ff, div_num_ff[NUM_WIDTH-1]};
   assign div_fits     = div_trial >= {1'b0, step_time_ff};
   assign div_rem_next = div_fits ? DT_WIDTH'(div_trial - {1'b0, step_time_ff})
                                  : div_trial[DT_WIDTH-1:0];

   // Integral update: floor shift, saturate, then anti-windup clamp
   assign int_prod = mul_acc_ff[PROD_WIDTH-1:0];
   assign int_step = STEP_WIDTH'(int_prod >>> DT_FRAC);
   assign int_sum  = ISUM_WIDTH'(int_step) + ISUM_WIDTH'(integ_ff);
   assign int_top  = int_sum[ISUM_WIDTH-1:DW-1];
   assign int_sat  = (&int_top || ~|int_top) ? int_sum[DW-1:0]
                                             : (int_sum[ISUM_WIDTH-1] ? SMIN : SMAX);

   // Derivative: signed, saturated quotient; zero for a zero step time
   assign quot_big  = |div_num_ff[NUM_WIDTH-1:DW-1];
   assign quot_low  = div_num_ff[DW-1:0];
   assign deriv_val = (step_time_ff == '0) ? '0 :
                      diff_neg_ff ? (quot_big ? SMIN : -$signed(quot_low))
                                  : (quot_big ? SMAX : $signed(quot_low));

   // Effort: floor shift of the product sum, saturate
   assign eff_shift = mul_acc_ff >>> FRAC_BITS;
   assign eff_top   = eff_shift[MUL_WIDTH-1:DW-1];
   assign eff_sat   = (&eff_top || ~|eff_top) ? eff_shift[DW-1:0]
                                              : (eff_shift[MUL_WIDTH-1] ? SMIN : SMAX);

   // Datapath
   always_comb begin
      err_in        = err_ff;
      last_err_in   = last_err_ff;
      integ_in      = integ_ff;
      deriv_in      = deriv_ff;
      eff_in        = eff_ff;
      diff_neg_in   = diff_neg_ff;
      term_in       = term_ff;
      mul_acc_in    = mul_acc_ff;
      mul_mcand_in  = mul_mcand_ff;
      mul_mplier_in = mul_mplier_ff;
      mul_left_in   = mul_left_ff;
      mul_signed_in = mul_signed_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_left_in   = div_left_ff;
      case (state_ff)
         ST_ERROR: err_in = err_sat;
         ST_PREP: begin
            // load divider with |diff| << 24 and multiplier with err * dt
            last_err_in   = err_ff;
            diff_neg_in   = err_diff[DW];
            div_num_in    = {err_mag, {DT_FRAC{1'b0}}};
            div_rem_in    = '0;
            div_left_in   = DIV_CNT_WIDTH'(NUM_WIDTH);
            mul_acc_in    = '0;
            mul_mcand_in  = MUL_WIDTH'(err_ff);
            mul_mplier_in = MPLIER_WIDTH'(step_time_ff);
            mul_left_in   = MUL_CNT_WIDTH'(DT_WIDTH);
            mul_signed_in = 1'b0;
         end
         ST_SERIAL, ST_MAC_RUN: begin
            if (mul_busy) begin
               mul_acc_in    = mul_sum;
               mul_mcand_in  = {mul_mcand_ff[MUL_WIDTH-2:0], 1'b0};
               mul_mplier_in = {1'b0, mul_mplier_ff[MPLIER_WIDTH-1:1]};
               mul_left_in   = mul_left_ff - MUL_CNT_WIDTH'(1);
            end else if (state_ff == ST_MAC_RUN) begin
               term_in = term_ff + 2'd1;
            end
            if (div_busy && state_ff == ST_SERIAL) begin
               div_rem_in  = div_rem_next;
               div_num_in  = {div_num_ff[NUM_WIDTH-2:0], div_fits};
               div_left_in = div_left_ff - DIV_CNT_WIDTH'(1);
            end
         end
         ST_INTEG: begin
            integ_in = clamp_value(int_sat, integ_floor_ff, integ_ceiling_ff);
            deriv_in = deriv_val;
            term_in  = TERM_PROP;
         end
         ST_MAC_LOAD: begin
            // accumulate gain * operand for the current term
            mul_left_in   = MUL_CNT_WIDTH'(DW);
            mul_signed_in = 1'b1;
            case (term_ff)
               TERM_PROP: begin
                  mul_acc_in    = '0;
                  mul_mcand_in  = MUL_WIDTH'(err_ff);
                  mul_mplier_in = MPLIER_WIDTH'($unsigned(prop_gain_ff));
               end
               TERM_INTEG: begin
                  mul_mcand_in  = MUL_WIDTH'(integ_ff);
                  mul_mplier_in = MPLIER_WIDTH'($unsigned(integ_gain_ff));
               end
               default: begin
                  mul_mcand_in  = MUL_WIDTH'(deriv_ff);
                  mul_mplier_in = MPLIER_WIDTH'($unsigned(deriv_gain_ff));
               end
            endcase
         end
         ST_EFFORT: eff_in = clamp_value(eff_sat, drive_floor_ff, drive_ceiling_ff);
         default: err_in = err_ff;
      endcase
   end

   // Response register: load when free or being taken, drop once taken
   assign rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_effort_in = rsp_load ? eff_ff : rsp_effort_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_effort    = rsp_effort_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         prop_gain_ff     <= '0;
         integ_gain_ff    <= '0;
         deriv_gain_ff    <= '0;
         integ_floor_ff   <= RST_FLOOR;
         integ_ceiling_ff <= RST_CEILING;
         drive_floor_ff   <= RST_FLOOR;
         drive_ceiling_ff <= RST_CEILING;
         integ_ff         <= '0;
         last_err_ff      <= '0;
         mul_left_ff      <= '0;
         div_left_ff      <= '0;
         term_ff          <= TERM_PROP;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         prop_gain_ff     <= prop_gain_in;
         integ_gain_ff    <= integ_gain_in;
         deriv_gain_ff    <= deriv_gain_in;
         integ_floor_ff   <= integ_floor_in;
         integ_ceiling_ff <= integ_ceiling_in;
         drive_floor_ff   <= drive_floor_in;
         drive_ceiling_ff <= drive_ceiling_in;
         integ_ff         <= integ_in;
         last_err_ff      <= last_err_in;
         mul_left_ff      <= mul_left_in;
         div_left_ff      <= div_left_in;
         term_ff          <= term_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         setpoint_ff  <= req_setpoint;
         measured_ff  <= req_measured;
         step_time_ff <= req_step_time;
      end
      err_ff        <= err_in;
      deriv_ff      <= deriv_in;
      eff_ff        <= eff_in;
      diff_neg_ff   <= diff_neg_in;
      mul_acc_ff    <= mul_acc_in;
      mul_mcand_ff  <= mul_mcand_in;
      mul_mplier_ff <= mul_mplier_in;
      mul_signed_ff <= mul_signed_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      rsp_effort_ff <= rsp_effort_in;
   end

endmodule

// ===== design/pidpc_checker.sv =====
// Port-level checks for the PID position controller, bound to the top level.
module pidpc_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_effort
);

   // Come out of reset idle, with no response pending
   assert property (@(posedge clock) reset |=> (req_ready && !rsp_valid))
      else $error("not idle after reset");

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_effort)))
      else $error("stalled response changed");

   // Work on one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   // A response never appears right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response without computation time");

   // Stay ready while no request arrives
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && !req_valid) |=> req_ready)
      else $error("ready dropped without a request");

endmodule

bind pid_position_controller pidpc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pidpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_effort (rsp_effort)
);

// ===== bench/pidpc_effort_checker.sv =====
// Effort checker: predicts each drive effort and compares it with the response.
module pidpc_effort_checker import pidpc_pkg::*; #(
   parameter int DATA_WIDTH     = 32,
   parameter int FRAC_BITS      = 16,
   parameter int CSR_WIDTH      = 32,
   parameter int CSR_ADDR_WIDTH = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_setpoint,
   input  logic signed [DATA_WIDTH-1:0] req_measured,
   input  logic        [DT_WIDTH-1:0]   req_step_time,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [DATA_WIDTH-1:0] rsp_effort,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [CSR_WIDTH-1:0]         csr_pwdata,
   input  logic [CSR_WIDTH-1:0]         csr_prdata,
   input  logic                         csr_pready,
   output int                           fail_count,
   output int                           outstanding
);

   localparam int ADDR_SHIFT = (DATA_WIDTH > 32) ? 3 : 2;

   typedef logic signed [127:0]           wide_t;
   typedef logic signed [DATA_WIDTH-1:0]  data_t;

   localparam wide_t DATA_MAX = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam wide_t DATA_MIN = -(wide_t'(1) <<< (DATA_WIDTH - 1));

   // Shadow of the register bank and of the controller state
   data_t gain_limits [NUM_REGS];
   data_t integ_sum;
   data_t prev_error;
   data_t effort_due [$];
   int    mismatches = 0;

   // Saturate a wide value to the data width
   function automatic data_t saturate(input wide_t v);
      if (v > DATA_MAX) return data_t'(DATA_MAX);
      if (v < DATA_MIN) return data_t'(DATA_MIN);
      return data_t'(v);
   endfunction

   // Raise to the floor first, then lower to the ceiling
   function automatic data_t limit(input data_t v, input data_t lo, input data_t hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Advance the integral and last error by one request; return the effort
   function automatic data_t next_effort(input data_t setpoint, input data_t measured,
                                         input logic [DT_WIDTH-1:0] step_time);
      wide_t dt_w, step_area, rate_num, total;
      data_t err, rate;
      dt_w = '0;
      dt_w[DT_WIDTH-1:0] = step_time;
      err = saturate(wide_t'(setpoint) - wide_t'(measured));

      // integrate with floor rounding, saturate, then apply the anti-windup clamp
      step_area = (wide_t'(err) * dt_w) >>> DT_FRAC;
      integ_sum = saturate(wide_t'(integ_sum) + step_area);
      integ_sum = limit(integ_sum, gain_limits[REG_INTEG_FLOOR],
                        gain_limits[REG_INTEG_CEILING]);

      // derivative truncates toward zero; zero step time gives none
      rate = '0;
      if (step_time != '0) begin
         rate_num = (wide_t'(err) - wide_t'(prev_error)) <<< DT_FRAC;
         rate = saturate(rate_num / dt_w);
      end
      prev_error = err;

      total = wide_t'(gain_limits[REG_PROP_GAIN]) * wide_t'(err)
            + wide_t'(gain_limits[REG_INTEG_GAIN]) * wide_t'(integ_sum)
            + wide_t'(gain_limits[REG_DERIV_GAIN]) * wide_t'(rate);
      return limit(saturate(total >>> FRAC_BITS), gain_limits[REG_DRIVE_FLOOR],
                   gain_limits[REG_DRIVE_CEILING]);
   endfunction

   always @(posedge clock) begin : watch
      int    idx;
      data_t want;
      if (reset) begin
         gain_limits[REG_PROP_GAIN]     = '0;
         gain_limits[REG_INTEG_GAIN]    = '0;
         gain_limits[REG_DERIV_GAIN]    = '0;
         gain_limits[REG_INTEG_CEILING] = saturate(wide_t'(100) <<< FRAC_BITS);
         gain_limits[REG_INTEG_FLOOR]   = saturate(-(wide_t'(100) <<< FRAC_BITS));
         gain_limits[REG_DRIVE_CEILING] = gain_limits[REG_INTEG_CEILING];
         gain_limits[REG_DRIVE_FLOOR]   = gain_limits[REG_INTEG_FLOOR];
         integ_sum  = '0;
         prev_error = '0;
         effort_due.delete();
      end else begin
         // track register writes, check read-back of mapped registers
         if (csr_psel && csr_penable && csr_pready) begin
            idx = int'(csr_paddr >> ADDR_SHIFT);
            if (idx < NUM_REGS) begin
               if (csr_pwrite) begin
                  gain_limits[idx] = data_t'(csr_pwdata);
               end else if (data_t'(csr_prdata) !== gain_limits[idx]) begin
                  $error("prdata: register %0d expected %0d, got %0d", idx,
                         gain_limits[idx], data_t'(csr_prdata));
                  mismatches++;
               end
            end
         end

         // compare each taken response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (effort_due.size() == 0) begin
               $error("effort: expected nothing, got %0d", rsp_effort);
               mismatches++;
            end else begin
               want = effort_due.pop_front();
               if (rsp_effort !== want) begin
                  $error("effort: expected %0d, got %0d", want, rsp_effort);
                  mismatches++;
               end
            end
         end

         // predict each accepted request
         if (req_valid && req_ready)
            effort_due.push_back(next_effort(req_setpoint, req_measured, req_step_time));
      end
      fail_count  <= mismatches;
      outstanding <= effort_due.size();
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives requests, register writes and response stalls, gives the verdict.
module tb import pidpc_pkg::*;;

   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_WIDTH      = 32;
   localparam int CSR_ADDR_WIDTH = REG_INDEX_WIDTH + 2;

   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int TAIL_CYCLES     = 200;
   localparam int RANDOM_PHASES   = 13;
   localparam int ITEMS_PER_PHASE = 100;

   typedef logic signed [DATA_WIDTH-1:0] data_t;

   localparam data_t DATA_MAX  = 32'sh7FFF_FFFF;
   localparam data_t DATA_MIN  = 32'sh8000_0000;
   localparam data_t ONE       = 32'sh0001_0000;
   localparam data_t POS_SPAN  = 200 * ONE;
   localparam data_t GAIN_SPAN = 4 * ONE;
   localparam logic [DT_WIDTH-1:0] ONE_SECOND = 32'h0100_0000;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   data_t                     req_setpoint  = '0;
   data_t                     req_measured  = '0;
   logic [DT_WIDTH-1:0]       req_step_time = '0;
   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   data_t                     rsp_effort;
   logic                      csr_psel      = 1'b0;
   logic                      csr_penable   = 1'b0;
   logic                      csr_pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr     = '0;
   logic [CSR_WIDTH-1:0]      csr_pwdata    = '0;
   logic [CSR_WIDTH-1:0]      csr_prdata;
   logic                      csr_pready;

   int    fail_count;
   int    outstanding;
   int    quiet_cycles = 0;
   bit    req_eager    = 1'b0;
   data_t reg_plan [NUM_REGS];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pid_position_controller #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) dut (.*);

   pidpc_effort_checker #(
      .DATA_WIDTH    (DATA_WIDTH),
      .FRAC_BITS     (FRAC_BITS),
      .CSR_WIDTH     (CSR_WIDTH),
      .CSR_ADDR_WIDTH(CSR_ADDR_WIDTH)
   ) checker_i (.*);

   // Abort when nothing has moved on any port for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** pid_position_controller: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One register bus transfer: setup phase, access phase until ready, then idle
   task automatic bus_access(input bit write, input int index, input data_t value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_WIDTH'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the planned settings, then read every address back
   task automatic program_regs();
      for (int i = 0; i < NUM_REGS; i++)
         bus_access(1'b1, i, reg_plan[i]);
      for (int i = 0; i <= NUM_REGS; i++)
         bus_access(1'b0, i, '0);
   endtask

   // Present one request after a random gap and hold it until taken
   task automatic send_request(input data_t setpoint, input data_t measured,
                               input logic [DT_WIDTH-1:0] step_time);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_setpoint  <= setpoint;
      req_measured  <= measured;
      req_step_time <= step_time;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted effort has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic data_t random_gain();
      case ($urandom_range(0, 7))
         0:       return DATA_MAX;
         1:       return DATA_MIN;
         2:       return $urandom;
         default: return $urandom_range(0, 2 * GAIN_SPAN) - GAIN_SPAN;
      endcase
   endfunction

   // Pick a clamp range: mostly ordered, sometimes inverted, full or default
   task automatic random_bounds(output data_t lo, output data_t hi);
      data_t a, b;
      a = $urandom_range(0, 2 * POS_SPAN) - POS_SPAN;
      b = a + $urandom_range(0, POS_SPAN);
      case ($urandom_range(0, 5))
         0: begin lo = DATA_MIN;   hi = DATA_MAX;  end
         1: begin lo = b;          hi = a;         end
         2: begin lo = -100 * ONE; hi = 100 * ONE; end
         default: begin lo = a;    hi = b;         end
      endcase
   endtask

   // Response side: wait for valid, stall a random while, then take it
   initial begin : receiver
      int pause;
      int taken;
      bit eager;
      taken = 0;
      eager = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) eager = ($urandom_range(0, 3) == 0);
         pause = eager ? 0 : $urandom_range(0, 17);
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (pause - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      data_t               sp, ms;
      logic [DT_WIDTH-1:0] dt;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default gains are zero: state still advances
      send_request(ONE, '0, ONE_SECOND);
      send_request('0, ONE, '0);
      drain();

      // unit-ish gains, full clamp ranges; an unmapped write must be ignored
      reg_plan[REG_PROP_GAIN]     = ONE;
      reg_plan[REG_INTEG_GAIN]    = ONE / 2;
      reg_plan[REG_DERIV_GAIN]    = ONE / 4;
      reg_plan[REG_INTEG_FLOOR]   = DATA_MIN;
      reg_plan[REG_INTEG_CEILING] = DATA_MAX;
      reg_plan[REG_DRIVE_FLOOR]   = DATA_MIN;
      reg_plan[REG_DRIVE_CEILING] = DATA_MAX;
      bus_access(1'b1, REG_UNMAPPED, DATA_MAX);
      program_regs();
      send_request(DATA_MAX, DATA_MIN, 32'hFFFF_FFFF);
      send_request(DATA_MIN, DATA_MAX, 32'hFFFF_FFFF);
      send_request('0, '0, '0);
      send_request(5 * ONE, 2 * ONE, ONE_SECOND);
      send_request(-3 * ONE, ONE, 32'd1);
      send_request(-3 * ONE, ONE, '0);
      send_request(DATA_MAX, '0, ONE_SECOND);
      drain();

      // inverted clamp ranges, extreme gains
      reg_plan[REG_PROP_GAIN]     = DATA_MAX;
      reg_plan[REG_INTEG_GAIN]    = DATA_MIN;
      reg_plan[REG_DERIV_GAIN]    = -1;
      reg_plan[REG_INTEG_FLOOR]   = 10 * ONE;
      reg_plan[REG_INTEG_CEILING] = -10 * ONE;
      reg_plan[REG_DRIVE_FLOOR]   = 50 * ONE;
      reg_plan[REG_DRIVE_CEILING] = -50 * ONE;
      program_regs();
      send_request(ONE, '0, ONE_SECOND);
      send_request(-ONE, '0, 32'h0010_0000);
      send_request('0, '0, '0);
      send_request(DATA_MIN, DATA_MAX, 32'd1);
      drain();

      // opposite extreme gains, tight integral clamp
      reg_plan[REG_PROP_GAIN]     = DATA_MIN;
      reg_plan[REG_INTEG_GAIN]    = DATA_MAX;
      reg_plan[REG_DERIV_GAIN]    = DATA_MIN;
      reg_plan[REG_INTEG_FLOOR]   = -ONE;
      reg_plan[REG_INTEG_CEILING] = ONE;
      reg_plan[REG_DRIVE_FLOOR]   = DATA_MIN;
      reg_plan[REG_DRIVE_CEILING] = DATA_MAX;
      program_regs();
      send_request(DATA_MAX, DATA_MIN, 32'd1);
      send_request(DATA_MIN, DATA_MAX, 32'd1);
      send_request('0, '0, 32'hFFFF_FFFF);
      send_request(32'sd1, '0, 32'd1);
      send_request(-32'sd1, '0, '0);
      send_request(DATA_MAX, DATA_MAX, 32'h8000_0000);
      drain();

      // random phases: fresh settings, then mostly plausible control steps
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_eager = ($urandom_range(0, 3) == 0);
         reg_plan[REG_PROP_GAIN]  = random_gain();
         reg_plan[REG_INTEG_GAIN] = random_gain();
         reg_plan[REG_DERIV_GAIN] = random_gain();
         random_bounds(reg_plan[REG_INTEG_FLOOR], reg_plan[REG_INTEG_CEILING]);
         random_bounds(reg_plan[REG_DRIVE_FLOOR], reg_plan[REG_DRIVE_CEILING]);
         program_regs();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            sp = $urandom_range(0, 2 * POS_SPAN) - POS_SPAN;
            ms = sp + $urandom_range(0, 40 * ONE) - 20 * ONE;
            dt = $urandom_range(32'h0005_0000, 32'h0060_0000);
            case ($urandom_range(0, 9))
               0: begin sp = $urandom; ms = $urandom; dt = $urandom; end
               1: dt = '0;
               2: dt = $urandom_range(1, 255);
               3: ms = $urandom_range(0, 2 * POS_SPAN) - POS_SPAN;
               default: ;
            endcase
            send_request(sp, ms, dt);
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** pid_position_controller: PASSED **");
      else
         $display("** pid_position_controller: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pidpc_pkg.sv
design/pid_position_controller.sv
design/pidpc_checker.sv
bench/pidpc_effort_checker.sv
bench/tb.sv
